/* src/tmat_pkg.sv */
// Package for the triangle minimum-angle test: widths, types and pipeline constants.
// Depends on nothing; every other file of the block imports it.
package tmat_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int EDGE_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * EDGE_W;
    localparam int OP_W        = PROD_W + 1;
    localparam int SPLIT_W     = (OP_W + 1) / 2;
    localparam int HI_W        = OP_W - SPLIT_W;
    localparam int SQ_W        = 2 * OP_W;
    localparam int THR_W       = 32;
    localparam int CHUNK_W     = 32;
    localparam int NCHUNK      = (SQ_W + CHUNK_W - 1) / CHUNK_W;
    localparam int PAD_W       = NCHUNK * CHUNK_W;
    localparam int RHS_W       = SQ_W + THR_W;
    localparam int STAGES      = 8;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [EDGE_W-1:0]      edge_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic [OP_W-1:0]               operand_t;
    typedef logic [SQ_W-1:0]               square_t;
    typedef logic [THR_W-1:0]              thr_t;
    typedef logic [RHS_W-1:0]              rhs_t;

    typedef struct packed {
        logic load_a;
        logic load_b;
    } stage_en_t;

endpackage

/* src/tmat_if.sv */
// Request channels of the triangle minimum-angle test: triangles, results and threshold writes.
// Depends on tmat_pkg for the coordinate and threshold types.
interface tmat_tri_if;
    import tmat_pkg::*;

    logic   valid;
    logic   ready;
    coord_t vertex_a_x;
    coord_t vertex_a_y;
    coord_t vertex_b_x;
    coord_t vertex_b_y;
    coord_t vertex_c_x;
    coord_t vertex_c_y;

    modport source (
        output valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y,
        input  ready
    );
    modport sink (
        input  valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y,
        output ready
    );
endinterface

interface tmat_res_if;
    logic valid;
    logic ready;
    logic meets_quality;
    logic degenerate;

    modport source (output valid, meets_quality, degenerate, input ready);
    modport sink (input valid, meets_quality, degenerate, output ready);
endinterface

interface tmat_cfg_if;
    import tmat_pkg::*;

    logic valid;
    logic ready;
    thr_t threshold_sine_sq;

    modport source (output valid, threshold_sine_sq, input ready);
    modport sink (input valid, threshold_sine_sq, output ready);
endinterface

/* src/triangle_min_angle_test.sv */
// Triangle minimum-angle test: an eight-stage pipeline that compares, for every vertex,
// the squared cross product scaled by 2^32 with threshold times both squared edge lengths.
// One triangle is taken every cycle while results are accepted, and a stalled result holds
// only the stages that are full behind it.
// Reset clears every stage valid bit and sets the threshold register to zero.
// Depends on tmat_pkg, tmat_if, tmat_split_mul and tmat_thr_mul.
module triangle_min_angle_test (
    input  logic      clk,
    input  logic      rst_n,
    tmat_tri_if.sink   triangle,
    tmat_res_if.source result,
    tmat_cfg_if.sink   cfg
);
    import tmat_pkg::*;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] adv;
    thr_t              thr_reg;

    edge_t   e0x_reg;
    edge_t   e0y_reg;
    edge_t   e1x_reg;
    edge_t   e1y_reg;
    edge_t   e2x_reg;
    edge_t   e2y_reg;
    prod_t   pa_reg;
    prod_t   pb_reg;
    prod_t   s0x_reg;
    prod_t   s0y_reg;
    prod_t   s1x_reg;
    prod_t   s1y_reg;
    prod_t   s2x_reg;
    prod_t   s2y_reg;
    logic signed [OP_W-1:0] cross_diff;
    operand_t cross_reg;
    operand_t n0_reg;
    operand_t n1_reg;
    operand_t n2_reg;
    logic     degen_reg [2:6];
    square_t  sq;
    square_t  nn01;
    square_t  nn12;
    square_t  nn20;
    square_t  sq5_reg;
    square_t  sq6_reg;
    rhs_t     rhs01;
    rhs_t     rhs12;
    rhs_t     rhs20;
    rhs_t     lhs;
    logic     meets_reg;
    logic     meets_next;
    logic     degen_out_reg;
    stage_en_t mul_en;
    stage_en_t thr_en;

    always_comb
    begin
        adv[STAGES-1] = !valid_reg[STAGES-1] || result.ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    always_comb
    begin
        valid_next    = valid_reg;
        if (adv[0])
        begin
            valid_next[0] = triangle.valid;
        end
        for (int k = 1; k < STAGES; k++)
        begin
            if (adv[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            thr_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cfg.valid)
            begin
                thr_reg <= cfg.threshold_sine_sq;
            end
        end
    end

    assign cfg.ready      = 1'b1;
    assign triangle.ready = adv[0];

    assign cross_diff = OP_W'(pa_reg) - OP_W'(pb_reg);

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            e0x_reg <= EDGE_W'(triangle.vertex_b_x) - EDGE_W'(triangle.vertex_a_x);
            e0y_reg <= EDGE_W'(triangle.vertex_b_y) - EDGE_W'(triangle.vertex_a_y);
            e1x_reg <= EDGE_W'(triangle.vertex_c_x) - EDGE_W'(triangle.vertex_b_x);
            e1y_reg <= EDGE_W'(triangle.vertex_c_y) - EDGE_W'(triangle.vertex_b_y);
            e2x_reg <= EDGE_W'(triangle.vertex_a_x) - EDGE_W'(triangle.vertex_c_x);
            e2y_reg <= EDGE_W'(triangle.vertex_a_y) - EDGE_W'(triangle.vertex_c_y);
        end
        if (adv[1])
        begin
            pa_reg  <= PROD_W'(e0x_reg) * PROD_W'(e1y_reg);
            pb_reg  <= PROD_W'(e0y_reg) * PROD_W'(e1x_reg);
            s0x_reg <= PROD_W'(e0x_reg) * PROD_W'(e0x_reg);
            s0y_reg <= PROD_W'(e0y_reg) * PROD_W'(e0y_reg);
            s1x_reg <= PROD_W'(e1x_reg) * PROD_W'(e1x_reg);
            s1y_reg <= PROD_W'(e1y_reg) * PROD_W'(e1y_reg);
            s2x_reg <= PROD_W'(e2x_reg) * PROD_W'(e2x_reg);
            s2y_reg <= PROD_W'(e2y_reg) * PROD_W'(e2y_reg);
        end
        if (adv[2])
        begin
            cross_reg    <= cross_diff[OP_W-1] ? operand_t'(-cross_diff)
                                               : operand_t'(cross_diff);
            n0_reg       <= OP_W'(unsigned'(s0x_reg)) + OP_W'(unsigned'(s0y_reg));
            n1_reg       <= OP_W'(unsigned'(s1x_reg)) + OP_W'(unsigned'(s1y_reg));
            n2_reg       <= OP_W'(unsigned'(s2x_reg)) + OP_W'(unsigned'(s2y_reg));
            degen_reg[2] <= (cross_diff == '0);
        end
        if (adv[3])
        begin
            degen_reg[3] <= degen_reg[2];
        end
        if (adv[4])
        begin
            degen_reg[4] <= degen_reg[3];
        end
        if (adv[5])
        begin
            degen_reg[5] <= degen_reg[4];
            sq5_reg      <= sq;
        end
        if (adv[6])
        begin
            degen_reg[6] <= degen_reg[5];
            sq6_reg      <= sq5_reg;
        end
        if (adv[7])
        begin
            meets_reg     <= meets_next;
            degen_out_reg <= degen_reg[6];
        end
    end

    assign mul_en.load_a = adv[3];
    assign mul_en.load_b = adv[4];
    assign thr_en.load_a = adv[5];
    assign thr_en.load_b = adv[6];

    tmat_split_mul u_mul_sq (.clk(clk), .en(mul_en), .a(cross_reg), .b(cross_reg), .p(sq));
    tmat_split_mul u_mul_01 (.clk(clk), .en(mul_en), .a(n0_reg), .b(n1_reg), .p(nn01));
    tmat_split_mul u_mul_12 (.clk(clk), .en(mul_en), .a(n1_reg), .b(n2_reg), .p(nn12));
    tmat_split_mul u_mul_20 (.clk(clk), .en(mul_en), .a(n2_reg), .b(n0_reg), .p(nn20));

    tmat_thr_mul u_thr_01 (.clk(clk), .en(thr_en), .nn(nn01), .thr(thr_reg), .rhs(rhs01));
    tmat_thr_mul u_thr_12 (.clk(clk), .en(thr_en), .nn(nn12), .thr(thr_reg), .rhs(rhs12));
    tmat_thr_mul u_thr_20 (.clk(clk), .en(thr_en), .nn(nn20), .thr(thr_reg), .rhs(rhs20));

    assign lhs = {sq6_reg, {THR_W{1'b0}}};

    always_comb
    begin
        meets_next = !degen_reg[6] && (lhs > rhs01) && (lhs > rhs12) && (lhs > rhs20);
    end

    assign result.valid         = valid_reg[STAGES-1];
    assign result.meets_quality = meets_reg;
    assign result.degenerate    = degen_out_reg;

endmodule

/* src/tmat_split_mul.sv */
// Two-stage unsigned multiplier built from half-width partial products.
// Depends on tmat_pkg for the operand widths and the stage enable struct.
module tmat_split_mul (
    input  logic                clk,
    input  tmat_pkg::stage_en_t en,
    input  tmat_pkg::operand_t  a,
    input  tmat_pkg::operand_t  b,
    output tmat_pkg::square_t   p
);
    import tmat_pkg::*;

    localparam int LL_W  = 2 * SPLIT_W;
    localparam int MID_W = SPLIT_W + HI_W;
    localparam int HH_W  = 2 * HI_W;

    logic [SPLIT_W-1:0] a_lo;
    logic [SPLIT_W-1:0] b_lo;
    logic [HI_W-1:0]    a_hi;
    logic [HI_W-1:0]    b_hi;
    logic [LL_W-1:0]    ll_reg;
    logic [MID_W-1:0]   lh_reg;
    logic [MID_W-1:0]   hl_reg;
    logic [HH_W-1:0]    hh_reg;
    logic [LL_W-1:0]    ll_next;
    logic [MID_W-1:0]   lh_next;
    logic [MID_W-1:0]   hl_next;
    logic [HH_W-1:0]    hh_next;
    square_t            p_reg;
    square_t            p_next;

    assign a_lo = a[SPLIT_W-1:0];
    assign b_lo = b[SPLIT_W-1:0];
    assign a_hi = a[OP_W-1:SPLIT_W];
    assign b_hi = b[OP_W-1:SPLIT_W];

    always_comb
    begin
        ll_next = LL_W'(a_lo) * LL_W'(b_lo);
        lh_next = MID_W'(a_lo) * MID_W'(b_hi);
        hl_next = MID_W'(a_hi) * MID_W'(b_lo);
        hh_next = HH_W'(a_hi) * HH_W'(b_hi);
    end

    always_comb
    begin
        p_next = (SQ_W'(hh_reg) << (2 * SPLIT_W))
               + ((SQ_W'(lh_reg) + SQ_W'(hl_reg)) << SPLIT_W)
               + SQ_W'(ll_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en.load_a)
        begin
            ll_reg <= ll_next;
            lh_reg <= lh_next;
            hl_reg <= hl_next;
            hh_reg <= hh_next;
        end
        if (en.load_b)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

/* src/tmat_thr_mul.sv */
// Two-stage product of an edge-length product with the threshold, in 32-bit chunks.
// Depends on tmat_pkg for the widths and the stage enable struct.
module tmat_thr_mul (
    input  logic                clk,
    input  tmat_pkg::stage_en_t en,
    input  tmat_pkg::square_t   nn,
    input  tmat_pkg::thr_t      thr,
    output tmat_pkg::rhs_t      rhs
);
    import tmat_pkg::*;

    localparam int PART_W = CHUNK_W + THR_W;

    logic [PAD_W-1:0]  nn_pad;
    logic [PART_W-1:0] part_reg [NCHUNK];
    logic [PART_W-1:0] part_next [NCHUNK];
    rhs_t              rhs_reg;
    rhs_t              rhs_next;

    assign nn_pad = PAD_W'(nn);

    always_comb
    begin
        for (int k = 0; k < NCHUNK; k++)
        begin
            part_next[k] = PART_W'(nn_pad[k*CHUNK_W +: CHUNK_W]) * PART_W'(thr);
        end
    end

    always_comb
    begin
        rhs_next = '0;
        for (int k = 0; k < NCHUNK; k++)
        begin
            rhs_next = rhs_next + (RHS_W'(part_reg[k]) << (CHUNK_W * k));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.load_a)
        begin
            for (int k = 0; k < NCHUNK; k++)
            begin
                part_reg[k] <= part_next[k];
            end
        end
        if (en.load_b)
        begin
            rhs_reg <= rhs_next;
        end
    end

    assign rhs = rhs_reg;

endmodule

/* verif/tb_triangle_min_angle_test.sv */
// Self-checking bench for the triangle minimum-angle test: directed and random triangles,
// threshold writes between phases, random idling on both channels and a long result stall.
// Depends on tmat_pkg, the tmat request interfaces and the triangle_min_angle_test RTL.
module tb_triangle_min_angle_test;
    import tmat_pkg::*;

    typedef struct packed {
        logic meets_quality;
        logic degenerate;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tmat_tri_if triangle_ch ();
    tmat_res_if result_ch ();
    tmat_cfg_if thr_ch ();

    verdict_t verdict_queue[$];
    thr_t     threshold_copy = '0;
    int       error_count = 0;
    int       tri_gap_max = 0;
    int       res_gap_max = 0;
    int       res_hold_off = 0;
    coord_t   extreme_coords[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};

    triangle_min_angle_test i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .triangle (triangle_ch),
        .result   (result_ch),
        .cfg      (thr_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit vertex_clears(logic [127:0] cross_sq, logic [127:0] na,
                                         logic [127:0] nb, thr_t thr);
        logic [127:0] lhs;
        logic [127:0] rhs;
        lhs = cross_sq << 32;
        rhs = {96'd0, thr} * na * nb;
        return lhs > rhs;
    endfunction

    function automatic verdict_t judge_triangle(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                                                coord_t cx, coord_t cy, thr_t thr);
        longint       e0x, e0y, e1x, e1y, e2x, e2y, area2;
        logic [127:0] cross_mag, cross_sq, n0, n1, n2;
        verdict_t     v;
        e0x = longint'(bx) - longint'(ax);
        e0y = longint'(by) - longint'(ay);
        e1x = longint'(cx) - longint'(bx);
        e1y = longint'(cy) - longint'(by);
        e2x = longint'(ax) - longint'(cx);
        e2y = longint'(ay) - longint'(cy);
        area2 = e0x * e1y - e0y * e1x;
        cross_mag = 128'(area2 < 0 ? -area2 : area2);
        cross_sq = cross_mag * cross_mag;
        n0 = 128'(e0x * e0x + e0y * e0y);
        n1 = 128'(e1x * e1x + e1y * e1y);
        n2 = 128'(e2x * e2x + e2y * e2y);
        v.degenerate = (area2 == 0);
        v.meets_quality = !v.degenerate && vertex_clears(cross_sq, n0, n1, thr)
                          && vertex_clears(cross_sq, n1, n2, thr)
                          && vertex_clears(cross_sq, n2, n0, thr);
        return v;
    endfunction

    // Valid is left high after a request is taken so that a back-to-back request needs
    // no second assignment in the same step; it is lowered before any gap instead.
    task automatic send_vertices(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                                 coord_t cx, coord_t cy);
        int gap;
        gap = $urandom_range(tri_gap_max, 0);
        if (gap > 0)
        begin
            triangle_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        triangle_ch.valid      <= 1'b1;
        triangle_ch.vertex_a_x <= ax;
        triangle_ch.vertex_a_y <= ay;
        triangle_ch.vertex_b_x <= bx;
        triangle_ch.vertex_b_y <= by;
        triangle_ch.vertex_c_x <= cx;
        triangle_ch.vertex_c_y <= cy;
        @(posedge clk);
        while (!triangle_ch.ready) @(posedge clk);
        verdict_queue = {verdict_queue,
                         judge_triangle(ax, ay, bx, by, cx, cy, threshold_copy)};
    endtask

    task automatic send_random_triangle();
        coord_t v[6];
        int     pick;
        int     ox, oy, dx, dy, k, m;
        pick = $urandom_range(99);
        if (pick < 35)
        begin
            foreach (v[i]) v[i] = coord_t'($urandom);
        end
        else if (pick < 55)
        begin
            foreach (v[i]) v[i] = coord_t'(int'($urandom_range(16)) - 8);
        end
        else if (pick < 80)
        begin
            ox = int'($urandom_range(2000)) - 1000;
            oy = int'($urandom_range(2000)) - 1000;
            dx = int'($urandom_range(60)) - 30;
            dy = int'($urandom_range(60)) - 30;
            k = int'($urandom_range(60)) - 30;
            m = int'($urandom_range(60)) - 30;
            v[0] = coord_t'(ox);
            v[1] = coord_t'(oy);
            v[2] = coord_t'(ox + k * dx);
            v[3] = coord_t'(oy + k * dy);
            v[4] = coord_t'(ox + m * dx);
            v[5] = coord_t'(oy + m * dy + (pick < 68 ? 0 : int'($urandom_range(2)) - 1));
        end
        else
        begin
            foreach (v[i]) v[i] = extreme_coords[$urandom_range(6)];
        end
        send_vertices(v[0], v[1], v[2], v[3], v[4], v[5]);
    endtask

    task automatic write_threshold(thr_t value);
        thr_ch.valid             <= 1'b1;
        thr_ch.threshold_sine_sq <= value;
        @(posedge clk);
        while (!thr_ch.ready) @(posedge clk);
        thr_ch.valid <= 1'b0;
        threshold_copy = value;
    endtask

    task automatic settle_pipeline();
        triangle_ch.valid <= 1'b0;
        while (verdict_queue.size() != 0) @(posedge clk);
    endtask

    task automatic new_phase(thr_t value);
        settle_pipeline();
        write_threshold(value);
    endtask

    task automatic test_degenerate();
        new_phase(32'h0000_0000);
        send_vertices(5, 5, 5, 5, 5, 5);
        send_vertices(0, 0, 0, 0, 7, 3);
        send_vertices(-32768, -32768, 0, 0, 32767, 32767);
        send_vertices(-32768, 32767, 0, 32767, 32767, 32767);
        send_vertices(-3, 9, 1, 1, 5, -7);
    endtask

    task automatic test_zero_threshold();
        new_phase(32'h0000_0000);
        send_vertices(0, 0, 1, 0, 0, 1);
        send_vertices(0, 0, 32767, 0, -32768, 1);
        send_vertices(-32768, -32768, 32767, -32768, -32768, 32767);
    endtask

    task automatic test_orientation();
        new_phase(32'h2000_0000);
        send_vertices(0, 0, 100, 0, 0, 100);
        send_vertices(0, 0, 0, 100, 100, 0);
        send_vertices(0, 0, 1000, 0, 500, 100);
        send_vertices(0, 0, 500, 100, 1000, 0);
        send_vertices(-20000, -5, 20000, 3, 1, 30000);
    endtask

    // A right isosceles triangle sits exactly on a threshold of one half, so it must fail
    // there and pass one step below.
    task automatic test_right_angle_limit();
        new_phase(32'h8000_0000);
        send_vertices(0, 0, 1000, 0, 0, 1000);
        send_vertices(32767, 32767, -32768, 32767, 32767, -32768);
        new_phase(32'h7FFF_FFFF);
        send_vertices(0, 0, 1000, 0, 0, 1000);
        send_vertices(32767, 32767, -32768, 32767, 32767, -32768);
    endtask

    task automatic test_full_threshold();
        new_phase(32'hFFFF_FFFF);
        send_vertices(0, 0, 30000, 0, 15000, 25981);
        send_vertices(0, 0, 1, 0, 0, 1);
        send_vertices(-32768, -32768, 32767, -32768, 0, 32767);
    endtask

    task automatic test_backpressure();
        new_phase(32'h1000_0000);
        tri_gap_max = 0;
        res_gap_max = 0;
        res_hold_off = 200;
        repeat (80) send_random_triangle();
    endtask

    task automatic test_random();
        thr_t thr;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: thr = '0;
                1: thr = '1;
                2: thr = 32'h8000_0000;
                3: thr = thr_t'($urandom_range(32'h4000_0000));
                4: thr = thr_t'($urandom_range(32'h1000_0000));
                5: thr = thr_t'($urandom);
                6: thr = thr_t'($urandom_range(32'h0100_0000));
                default: thr = thr_t'($urandom_range(32'h2000_0000));
            endcase
            tri_gap_max = (phase % 2 == 0) ? 0 : 9;
            res_gap_max = (phase % 4 < 2) ? 0 : 9;
            new_phase(thr);
            repeat (200) send_random_triangle();
        end
    endtask

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (verdict_queue.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0b %0b",
                         $time, result_ch.meets_quality, result_ch.degenerate);
                error_count++;
            end
            else
            begin
                want = verdict_queue.pop_front();
                if (result_ch.meets_quality !== want.meets_quality)
                begin
                    $display("%0t: meets_quality expected %0b actual %0b",
                             $time, want.meets_quality, result_ch.meets_quality);
                    error_count++;
                end
                if (result_ch.degenerate !== want.degenerate)
                begin
                    $display("%0t: degenerate expected %0b actual %0b",
                             $time, want.degenerate, result_ch.degenerate);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        int gap;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (res_hold_off > 0)
            begin
                gap = res_hold_off;
                res_hold_off = 0;
            end
            else
                gap = $urandom_range(res_gap_max, 0);
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid && res_hold_off == 0) @(posedge clk);
        end
    end

    initial
    begin
        triangle_ch.valid        <= 1'b0;
        triangle_ch.vertex_a_x   <= '0;
        triangle_ch.vertex_a_y   <= '0;
        triangle_ch.vertex_b_x   <= '0;
        triangle_ch.vertex_b_y   <= '0;
        triangle_ch.vertex_c_x   <= '0;
        triangle_ch.vertex_c_y   <= '0;
        thr_ch.valid             <= 1'b0;
        thr_ch.threshold_sine_sq <= '0;
        tri_gap_max = 9;
        res_gap_max = 9;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_degenerate();
        test_zero_threshold();
        test_orientation();
        test_right_angle_limit();
        test_full_threshold();
        test_backpressure();
        test_random();
        settle_pipeline();
        repeat (STAGES + 4) @(posedge clk);
        if (error_count == 0)
            $display("triangle_min_angle_test: match");
        else
            $display("triangle_min_angle_test: mismatch");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("triangle_min_angle_test: mismatch");
        $finish;
    end

endmodule

/* sim.f */
src/tmat_pkg.sv
src/tmat_if.sv
src/tmat_split_mul.sv
src/tmat_thr_mul.sv
src/triangle_min_angle_test.sv
verif/tb_triangle_min_angle_test.sv
